FILE: rtl/sfla_pkg.sv
package sfla_pkg;

    localparam int BucketCount   = 56;
    localparam int LinearFour    = 64;
    localparam int LinearSixteen = 512;
    localparam int LargestClass  = 1048576;
    localparam int NodeCount     = 4096;

    localparam int BucketW = $clog2(BucketCount);
    localparam int NodeW   = $clog2(NodeCount);
    localparam int LinkW   = NodeW + 1;
    localparam int SizeW   = 24;
    localparam int StepW   = NodeW + 1;

    localparam int Base4  = (LinearFour - 1) / 4 + 1;
    localparam int Base16 = Base4 + ((LinearSixteen > LinearFour) ?
                            (LinearSixteen - LinearFour - 1) / 16 : 0) + 1;
    localparam int Log16  = $clog2(LinearSixteen + 1) - 1;

    localparam logic [LinkW-1:0] NilLink = LinkW'(NodeCount);

    typedef enum logic [1:0] {
        K_REQUEST = 2'd0,
        K_ADD     = 2'd1,
        K_DELETE  = 2'd2,
        K_BAD     = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE_RD,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_NODE_RD,
        S_NODE_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [BucketW-1:0] bucket;
        logic               head_we;
        logic [LinkW-1:0]   head_wdata;
    } t_head_ctl;

    function automatic logic [5:0] flog2(input logic [SizeW-1:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < SizeW; i++) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [BucketW-1:0] lookup_bucket(input logic [SizeW-1:0] s);
        logic [SizeW-1:0] b;
        logic [5:0]       a;
        a = flog2(s - SizeW'(1));
        if (s <= SizeW'(LinearFour)) begin
            b = (s == '0) ? '0 : ((s - SizeW'(1)) >> 2);
        end else if (s <= SizeW'(LinearSixteen)) begin
            b = SizeW'(Base4) + ((s - SizeW'(LinearFour) - SizeW'(1)) >> 4);
        end else if (s <= SizeW'(LargestClass)) begin
            b = SizeW'(Base16) + ((a >= 6'(Log16)) ? SizeW'(a - 6'(Log16)) : '0);
        end else begin
            b = SizeW'(BucketCount - 1);
        end
        if (b > SizeW'(BucketCount - 1)) begin
            b = SizeW'(BucketCount - 1);
        end
        return b[BucketW-1:0];
    endfunction

endpackage

FILE: rtl/sfla_heads.sv
module sfla_heads
    import sfla_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_head_ctl        i_ctl,
    output logic [LinkW-1:0] o_head
);

    logic [BucketCount-1:0] r_valid;
    logic [LinkW-1:0]       r_mem [BucketCount];
    logic [LinkW-1:0]       r_rd;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_ctl.bucket];
            if (i_ctl.head_we) begin
                r_valid[i_ctl.bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_ctl.bucket];
        if (i_ctl.head_we) begin
            r_mem[i_ctl.bucket] <= i_ctl.head_wdata;
        end
    end

    assign o_head = r_rd_valid ? r_rd : NilLink;

endmodule

FILE: rtl/sfla_nodes.sv
module sfla_nodes
    import sfla_pkg::*;
(
    input  logic             i_clk,
    input  logic [NodeW-1:0] i_addr,
    input  logic             i_we,
    input  logic             i_size_we,
    input  logic [LinkW-1:0] i_link_wdata,
    input  logic [SizeW-1:0] i_size_wdata,
    output logic [LinkW-1:0] o_link,
    output logic [SizeW-1:0] o_size
);

    logic [LinkW-1:0] r_link [NodeCount];
    logic [SizeW-1:0] r_size [NodeCount];

    always_ff @(posedge i_clk) begin
        o_link <= r_link[i_addr];
        if (i_we) begin
            r_link[i_addr] <= i_link_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_size <= r_size[i_addr];
        if (i_size_we) begin
            r_size[i_addr] <= i_size_wdata;
        end
    end

endmodule

FILE: rtl/segregated_free_list_allocator.sv
// Channel  | Dir | tdata (low bit up)                      | tuser
// s_axis   | in  | block_size[23:0], block_index[35:24]    | kind[1:0]
// m_axis   | out | found_index[11:0]                       | status
//
// One item at a time. For an add the result follows the head read and head
// wait states; an unknown kind goes straight to the result. A request reads
// each bucket head and then each list node it checks; a delete first reads
// the size of its node. Each read is followed by a wait state for its registered memory. Reset empties all
// buckets at once; no clearing pass. A waiting result holds until taken; the
// next beat is accepted in the cycle after it leaves.
module segregated_free_list_allocator
    import sfla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // block_size, block_index, pad
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // found_index, pad
    output logic        m_axis_tuser    // status
);

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [SizeW-1:0]   r_size, n_size;
    logic [NodeW-1:0]   r_idx, n_idx;
    logic [BucketW-1:0] r_bucket, n_bucket;
    logic [LinkW-1:0]   r_cur, n_cur;
    logic [LinkW-1:0]   r_prev, n_prev;
    logic [StepW-1:0]   r_steps, n_steps;
    logic               r_status, n_status;
    logic [NodeW-1:0]   r_found, n_found;

    t_head_ctl          head_ctl;
    logic [LinkW-1:0]   head_rd;
    logic [NodeW-1:0]   node_addr;
    logic               node_we, size_we;
    logic [LinkW-1:0]   link_wdata;
    logic [LinkW-1:0]   link_rd;
    logic [SizeW-1:0]   size_rd;

    sfla_heads u_heads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (head_ctl),
        .o_head  (head_rd)
    );

    sfla_nodes u_nodes (
        .i_clk        (i_clk),
        .i_addr       (node_addr),
        .i_we         (node_we),
        .i_size_we    (size_we),
        .i_link_wdata (link_wdata),
        .i_size_wdata (r_size),
        .o_link       (link_rd),
        .o_size       (size_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_kind   <= n_kind;
        r_size   <= n_size;
        r_idx    <= n_idx;
        r_bucket <= n_bucket;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_size   = r_size;
        n_idx    = r_idx;
        n_bucket = r_bucket;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_status = r_status;
        n_found  = r_found;
        head_ctl.bucket     = r_bucket;
        head_ctl.head_we    = 1'b0;
        head_ctl.head_wdata = head_rd;
        node_addr  = r_cur[NodeW-1:0];
        node_we    = 1'b0;
        size_we    = 1'b0;
        link_wdata = link_rd;
        s_axis_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind   = t_kind'(s_axis_tuser);
                    n_size   = s_axis_tdata[23:0];
                    n_idx    = s_axis_tdata[35:24];
                    n_status = 1'b1;
                    n_found  = '0;
                    n_steps  = '0;
                    n_prev   = NilLink;
                    n_bucket = lookup_bucket(s_axis_tdata[23:0]);
                    n_cur    = {1'b0, s_axis_tdata[35:24]};
                    case (t_kind'(s_axis_tuser))
                        K_REQUEST: n_state = S_HEAD_RD;
                        K_ADD:     n_state = S_HEAD_RD;
                        K_DELETE:  n_state = S_SIZE_RD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SIZE_RD: begin
                node_addr = r_idx;
                n_state   = S_NODE_WAIT;
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                n_steps = '0;
                n_prev  = NilLink;
                if (r_kind == K_ADD) begin
                    node_addr           = r_idx;
                    node_we             = 1'b1;
                    size_we             = 1'b1;
                    link_wdata          = head_rd;
                    head_ctl.head_we    = 1'b1;
                    head_ctl.head_wdata = {1'b0, r_idx};
                    n_status            = 1'b0;
                    n_state             = S_DONE;
                end else begin
                    n_cur = head_rd;
                    if (head_rd >= NilLink) begin
                        if (r_kind == K_REQUEST &&
                            r_bucket != BucketW'(BucketCount - 1)) begin
                            n_bucket = r_bucket + BucketW'(1);
                            n_state  = S_HEAD_RD;
                        end else begin
                            n_found = '0;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_NODE_RD;
                    end
                end
            end
            S_NODE_RD: begin
                node_addr = r_cur[NodeW-1:0];
                n_state   = S_NODE_WAIT;
            end
            S_NODE_WAIT: begin
                if (r_kind == K_DELETE && r_found == '0 &&
                    r_steps == '0 && r_prev == NilLink) begin
                    n_found  = NodeW'(1);
                    n_bucket = lookup_bucket(size_rd);
                    n_state  = S_HEAD_RD;
                end else if (r_kind == K_REQUEST) begin
                    if (size_rd >= r_size) begin
                        n_status = 1'b0;
                        n_found  = r_cur[NodeW-1:0];
                        n_state  = S_DONE;
                    end else if (link_rd >= NilLink ||
                                 r_steps == StepW'(NodeCount - 1)) begin
                        if (r_bucket != BucketW'(BucketCount - 1)) begin
                            n_bucket = r_bucket + BucketW'(1);
                            n_state  = S_HEAD_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_prev  = r_cur;
                        n_cur   = link_rd;
                        n_steps = r_steps + StepW'(1);
                        n_state = S_NODE_RD;
                    end
                end else begin
                    if (r_cur == {1'b0, r_idx}) begin
                        if (r_prev == NilLink) begin
                            head_ctl.head_we    = 1'b1;
                            head_ctl.head_wdata = link_rd;
                        end else begin
                            node_addr  = r_prev[NodeW-1:0];
                            node_we    = 1'b1;
                            link_wdata = link_rd;
                        end
                        n_status = 1'b0;
                        n_found  = '0;
                        n_state  = S_DONE;
                    end else if (link_rd >= NilLink ||
                                 r_steps == StepW'(NodeCount - 1)) begin
                        n_found = '0;
                        n_state = S_DONE;
                    end else begin
                        n_prev  = r_cur;
                        n_cur   = link_rd;
                        n_steps = r_steps + StepW'(1);
                        n_state = S_NODE_RD;
                    end
                end
            end
            S_DONE: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tdata  = {4'b0, r_found};
    assign m_axis_tuser  = r_status;

endmodule

FILE: tb/sv/sfla_scoreboard.sv
`timescale 1ns / 1ps

module sfla_scoreboard
    import sfla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // block_size[23:0], block_index[35:24], pad
    input  logic [1:0]  i_s_tuser,   // kind
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // found_index[11:0], pad
    input  logic        i_m_tuser,   // status
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        status;
        logic [11:0] found;
    } t_outcome;

    logic [LinkW-1:0] heads [BucketCount];
    logic [LinkW-1:0] links [NodeCount];
    logic [SizeW-1:0] sizes [NodeCount];
    t_outcome         outcome_q [$];

    function automatic int size_class(input logic [SizeW-1:0] s);
        int cls;
        int lg;
        cls = 0;
        lg = 0;
        if (s == 0) begin
            cls = 0;
        end else if (s <= LinearFour) begin
            cls = (s - 1) / 4;
        end else if (s <= LinearSixteen) begin
            cls = Base4 + (s - LinearFour - 1) / 16;
        end else if (s <= LargestClass) begin
            for (int v = s - 1; v > 1; v = v / 2) begin
                lg++;
            end
            cls = Base16 + ((lg >= Log16) ? lg - Log16 : 0);
        end else begin
            cls = BucketCount - 1;
        end
        if (cls > BucketCount - 1) begin
            cls = BucketCount - 1;
        end
        return cls;
    endfunction

    function automatic t_outcome apply_item(input t_kind kind, input logic [SizeW-1:0] size,
                                            input logic [11:0] idx);
        t_outcome res;
        int       b;
        int       cur;
        int       prev;
        int       steps;
        bit       hit;
        res = '{status: 1'b1, found: '0};
        hit = 0;
        case (kind)
            K_REQUEST: begin
                for (b = size_class(size); b < BucketCount && !hit; b++) begin
                    cur = heads[b];
                    steps = 0;
                    while (cur < NodeCount && steps < NodeCount && !hit) begin
                        if (sizes[cur] >= size) begin
                            hit = 1;
                            res = '{status: 1'b0, found: cur[11:0]};
                        end else begin
                            cur = links[cur];
                            steps++;
                        end
                    end
                end
            end
            K_ADD: begin
                b = size_class(size);
                links[idx] = heads[b];
                sizes[idx] = size;
                heads[b] = LinkW'(idx);
                res.status = 1'b0;
            end
            K_DELETE: begin
                b = size_class(sizes[idx]);
                prev = NodeCount;
                cur = heads[b];
                steps = 0;
                while (cur < NodeCount && steps < NodeCount && !hit) begin
                    if (cur == idx) begin
                        if (prev == NodeCount) begin
                            heads[b] = links[cur];
                        end else begin
                            links[prev] = links[cur];
                        end
                        res.status = 1'b0;
                        hit = 1;
                    end else begin
                        prev = cur;
                        cur = links[cur];
                        steps++;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        foreach (heads[i]) heads[i] = NilLink;
        foreach (links[i]) links[i] = '0;
        foreach (sizes[i]) sizes[i] = '0;
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected beat", i_m_tdata[11:0], -1);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_m_tuser !== want.status) begin
                        report_mismatch("status", i_m_tuser, want.status);
                    end
                    if (i_m_tdata[11:0] !== want.found) begin
                        report_mismatch("found_index", i_m_tdata[11:0], want.found);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                outcome_q.push_back(apply_item(t_kind'(i_s_tuser), i_s_tdata[23:0],
                                               i_s_tdata[35:24]));
            end
            o_pending <= outcome_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_segregated_free_list_allocator.sv
`timescale 1ns / 1ps

module tb_segregated_free_list_allocator;
    import sfla_pkg::*;

    localparam int StallLimit = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // block_size[23:0], block_index[35:24], pad
    logic [1:0]  s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // found_index[11:0], pad
    logic        m_axis_tuser;   // status
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    bit          listed [NodeCount];
    logic [11:0] live_q [$];
    logic [11:0] retired_q [$];

    segregated_free_list_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sfla_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stall the result side
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input t_kind kind, input logic [23:0] size, input logic [11:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {4'h0, idx, size};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 40'($urandom);
    endtask

    task automatic add_block(input logic [23:0] size, input logic [11:0] idx);
        send_item(K_ADD, size, idx);
        listed[idx] = 1'b1;
        live_q.push_back(idx);
    endtask

    function automatic logic [23:0] pick_size();
        case ($urandom_range(9))
            0, 1, 2, 3: return 24'($urandom_range(64, 1));
            4, 5:       return 24'($urandom_range(512, 65));
            6, 7:       return 24'($urandom_range(LargestClass, 513));
            8:          return 24'($urandom);
            default:    return ($urandom_range(1)) ? 24'd0 : 24'hFFFFFF;
        endcase
    endfunction

    task automatic random_item();
        int          pos;
        logic [11:0] idx;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 45 && live_q.size() < 400) begin
            idx = 12'($urandom_range(3999));
            while (listed[idx]) idx = 12'($urandom_range(3999));
            add_block(pick_size(), idx);
        end else if (roll < 75) begin
            send_item(K_REQUEST, pick_size(), 12'($urandom));
        end else if (roll < 95 && live_q.size() > 0) begin
            pos = $urandom_range(live_q.size() - 1);
            idx = live_q[pos];
            live_q.delete(pos);
            listed[idx] = 1'b0;
            retired_q.push_back(idx);
            send_item(K_DELETE, 24'($urandom), idx);
        end else if (roll < 97 && retired_q.size() > 0) begin
            send_item(K_DELETE, 24'($urandom),
                      retired_q[$urandom_range(retired_q.size() - 1)]);
        end else begin
            send_item(K_BAD, 24'($urandom), 12'($urandom));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = K_REQUEST;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        foreach (listed[i]) listed[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(K_REQUEST, 24'd0, 12'd0);
        add_block(24'd1, 12'd4095);
        add_block(24'd4, 12'd4001);
        add_block(24'd5, 12'd4002);
        add_block(24'd64, 12'd4003);
        add_block(24'd65, 12'd4004);
        add_block(24'd512, 12'd4005);
        add_block(24'd513, 12'd4006);
        add_block(24'd1048576, 12'd4007);
        add_block(24'd1048577, 12'd4008);
        add_block(24'hFFFFFF, 12'd4009);
        add_block(24'd0, 12'd4010);
        send_item(K_REQUEST, 24'd0, 12'hFFF);
        send_item(K_REQUEST, 24'd1, 12'd0);
        send_item(K_REQUEST, 24'd600, 12'd0);
        send_item(K_REQUEST, 24'd2000000, 12'd0);
        send_item(K_REQUEST, 24'hFFFFFF, 12'd0);
        // unlink head of a bucket, then its tail node, then an absent one
        add_block(24'd3, 12'd4011);
        send_item(K_DELETE, 24'd0, 12'd4011);
        send_item(K_DELETE, 24'd0, 12'd4095);
        send_item(K_DELETE, 24'd0, 12'd4095);
        send_item(K_BAD, 24'hFFFFFF, 12'hFFF);
        // re-add a listed block into another bucket; never reuse it
        send_item(K_ADD, 24'd100, 12'd4020);
        send_item(K_ADD, 24'd3000, 12'd4020);
        send_item(K_REQUEST, 24'd90, 12'd0);
        send_item(K_DELETE, 24'd0, 12'd4020);
        listed[12'd4095] = 1'b0;
        listed[12'd4011] = 1'b0;
        for (int i = live_q.size() - 1; i >= 0; i--) begin
            if (live_q[i] == 12'd4095 || live_q[i] == 12'd4011) live_q.delete(i);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (int n = 0; n < 200; n++) begin
                random_item();
            end
            // hold off until the pipe drains
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
        end

        recv_stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
